[src/fmp_pkg.sv]
// Shared types, control-word layout and microcode store of the Fibonacci-mod-m block.
`default_nettype none

package fmp_pkg;

    // Width of the step counter and the step addresses of the program
    localparam int STEP_W = 3;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE    = 3'd0;
    localparam step_t STEP_CHECK   = 3'd1;
    localparam step_t STEP_PSTEP   = 3'd2;
    localparam step_t STEP_DIVINIT = 3'd3;
    localparam step_t STEP_DIVSTEP = 3'd4;
    localparam step_t STEP_FSTEP   = 3'd5;
    localparam step_t STEP_OUT     = 3'd6;
    localparam step_t STEP_JUMP    = 3'd7;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_LOAD    = 3'd1,
        OP_PSTEP   = 3'd2,
        OP_DIVINIT = 3'd3,
        OP_DIVSTEP = 3'd4,
        OP_FSTEP   = 3'd5,
        OP_OUT     = 3'd6
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER     = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_NO_INPUT  = 3'd2,
        COND_MOD_SMALL = 3'd3,
        COND_NOT_FOUND = 3'd4,
        COND_BITS_LEFT = 3'd5,
        COND_REM_LEFT  = 3'd6,
        COND_OUT_BUSY  = 3'd7
    } cond_t;

    // One control word: operation, jump condition, jump target
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic found;
        logic bits_left;
        logic rem_left;
        logic mod_small;
        logic out_busy;
    } fmp_status_t;

    // Microcode: a jump is taken when its condition holds, else the step counter advances
    function automatic ctrl_word_t rom_word(input step_t pc);
        ctrl_word_t w;
        unique case (pc)
            STEP_IDLE:    w = '{OP_LOAD,    COND_NO_INPUT,  STEP_IDLE};
            STEP_CHECK:   w = '{OP_NONE,    COND_MOD_SMALL, STEP_OUT};
            STEP_PSTEP:   w = '{OP_PSTEP,   COND_NOT_FOUND, STEP_PSTEP};
            STEP_DIVINIT: w = '{OP_DIVINIT, COND_NEVER,     STEP_IDLE};
            STEP_DIVSTEP: w = '{OP_DIVSTEP, COND_BITS_LEFT, STEP_DIVSTEP};
            STEP_FSTEP:   w = '{OP_FSTEP,   COND_REM_LEFT,  STEP_FSTEP};
            STEP_OUT:     w = '{OP_OUT,     COND_OUT_BUSY,  STEP_OUT};
            STEP_JUMP:    w = '{OP_NONE,    COND_ALWAYS,    STEP_IDLE};
            default:      w = '{OP_NONE,    COND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[src/fmp_sequencer.sv]
// Step counter and microcode store that drive the Fibonacci-mod-m datapath.
`default_nettype none

module fmp_sequencer
    import fmp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire fmp_status_t status,
    output ctrl_word_t       ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  take_jump;

    // Fetch the control word of the current step
    assign ctrl = rom_word(pc_reg);

    // Evaluate the jump condition
    always_comb begin
        unique case (ctrl.cond)
            COND_NEVER:     take_jump = 1'b0;
            COND_ALWAYS:    take_jump = 1'b1;
            COND_NO_INPUT:  take_jump = !in_valid;
            COND_MOD_SMALL: take_jump = status.mod_small;
            COND_NOT_FOUND: take_jump = !status.found;
            COND_BITS_LEFT: take_jump = status.bits_left;
            COND_REM_LEFT:  take_jump = status.rem_left;
            COND_OUT_BUSY:  take_jump = status.out_busy;
            default:        take_jump = 1'b1;
        endcase
        pc_next = take_jump ? ctrl.target : step_t'(pc_reg + 1'b1);
    end

    // Advance the step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

`ifndef SYNTHESIS
    // Leaving the idle step needs a word to have arrived
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == STEP_IDLE && !in_valid) |=> (pc_reg == STEP_IDLE))
        else $error("sequencer left idle without a word");

    // The division loop is entered only from its set-up step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == STEP_DIVSTEP && $past(pc_reg) != STEP_DIVSTEP) |->
        ($past(pc_reg) == STEP_DIVINIT))
        else $error("division entered without set-up");

    // The output step is reached only from the check or the stepping loop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == STEP_OUT && $past(pc_reg) != STEP_OUT) |->
        ($past(pc_reg) == STEP_CHECK || $past(pc_reg) == STEP_FSTEP))
        else $error("output step reached out of order");
`endif

endmodule

`default_nettype wire

[src/fmp_datapath.sv]
// Pair registers, period counter, bit-serial divider and output register.
`default_nettype none

module fmp_datapath
    import fmp_pkg::*;
#(
    parameter int MOD_WIDTH   = 16,
    parameter int INDEX_WIDTH = 63
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ctrl_word_t             ctrl,
    input  wire logic                   in_valid,
    input  wire logic [INDEX_WIDTH-1:0] in_index,
    input  wire logic [MOD_WIDTH-1:0]   in_mod,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic [MOD_WIDTH-1:0]        out_data,
    output fmp_status_t                 status
);

    // Pisano period is at most 6m, so three bits above the modulus width
    localparam int PW = MOD_WIDTH + 3;
    localparam int BW = $clog2(INDEX_WIDTH);
    localparam logic [BW-1:0] LAST_BIT = BW'(INDEX_WIDTH - 1);
    localparam logic [MOD_WIDTH-1:0] MOD_ONE = MOD_WIDTH'(1);
    localparam logic [PW-1:0] PER_ONE = PW'(1);

    logic [INDEX_WIDTH-1:0] n_reg,   n_next;
    logic [MOD_WIDTH-1:0]   m_reg,   m_next;
    logic [MOD_WIDTH-1:0]   a_reg,   a_next;
    logic [MOD_WIDTH-1:0]   b_reg,   b_next;
    logic [PW-1:0]          per_reg, per_next;
    logic [PW-1:0]          rem_reg, rem_next;
    logic [BW-1:0]          bit_reg, bit_next;
    logic [MOD_WIDTH-1:0]   res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;

    logic [MOD_WIDTH:0]     pair_sum;
    logic [MOD_WIDTH-1:0]   sum_mod;
    logic [PW:0]            trial;
    logic [PW:0]            trial_diff;
    logic                   load_out;

    // Next pair term: (a + b) mod m with one compare and subtract
    always_comb begin
        pair_sum = {1'b0, a_reg} + {1'b0, b_reg};
        if (pair_sum >= {1'b0, m_reg}) begin
            sum_mod = MOD_WIDTH'(pair_sum - {1'b0, m_reg});
        end else begin
            sum_mod = pair_sum[MOD_WIDTH-1:0];
        end
    end

    // One restoring-division step: shift in the next index bit
    always_comb begin
        trial      = {rem_reg, n_reg[INDEX_WIDTH-1]};
        trial_diff = trial - {1'b0, per_reg};
    end

    assign load_out = (ctrl.op == OP_OUT) && !(out_valid_reg && !out_ready);

    // Datapath register updates
    always_comb begin
        n_next         = n_reg;
        m_next         = m_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        per_next       = per_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (ctrl.op)
            OP_LOAD: begin
                if (in_valid) begin
                    n_next   = in_index;
                    m_next   = in_mod;
                    a_next   = '0;
                    b_next   = MOD_ONE;
                    per_next = '0;
                end
            end
            OP_PSTEP: begin
                a_next   = b_reg;
                b_next   = sum_mod;
                per_next = per_reg + PER_ONE;
            end
            OP_DIVINIT: begin
                rem_next = '0;
                bit_next = LAST_BIT;
            end
            OP_DIVSTEP: begin
                if (trial >= {1'b0, per_reg}) begin
                    rem_next = trial_diff[PW-1:0];
                end else begin
                    rem_next = trial[PW-1:0];
                end
                n_next   = {n_reg[INDEX_WIDTH-2:0], 1'b0};
                bit_next = bit_reg - 1'b1;
            end
            OP_FSTEP: begin
                if (rem_reg != '0) begin
                    a_next   = b_reg;
                    b_next   = sum_mod;
                    rem_next = rem_reg - PER_ONE;
                end
            end
            OP_OUT: begin
                if (load_out) begin
                    res_next       = a_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold the output handshake state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        m_reg   <= m_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        per_reg <= per_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        res_reg <= res_next;
    end

    // Flags for the sequencer
    assign status.found     = (b_reg == '0) && (sum_mod == MOD_ONE);
    assign status.bits_left = (bit_reg != '0);
    assign status.rem_left  = (rem_reg != '0);
    assign status.mod_small = (m_reg <= MOD_ONE);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

`ifndef SYNTHESIS
    // The pair stays reduced while the period is searched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_PSTEP) |-> (a_reg < m_reg && b_reg < m_reg))
        else $error("pair left its residue range");

    // The reduced index stays below the period while stepping
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_FSTEP) |-> (rem_reg < per_reg))
        else $error("reduced index not below period");

    // A loaded result is a residue, or zero for a modulus of zero or one
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (a_reg < m_reg || (m_reg <= MOD_ONE && a_reg == '0)))
        else $error("result out of range");

    // A loaded result shows on the output in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (out_valid_reg && res_reg == $past(a_reg)))
        else $error("result not presented");
`endif

endmodule

`default_nettype wire

[src/fibonacci_mod_pisano.sv]
// Top level of the Fibonacci-mod-m block: stream ports, sequencer and datapath.
`default_nettype none

// Returns F(n) mod m for one word (index n, modulus m) on the slave side, one
// result word on the master side. A short microprogram drives one adder with
// a reducing subtract: it first steps the pair (a, b) -> (b, (a+b) mod m) from
// (0, 1) until (0, 1) comes back, counting the Pisano period p (at most 6m
// steps), then reduces n modulo p with a restoring divider that takes one
// index bit a cycle, then steps the pair n mod p times. A modulus of 0 or 1
// returns 0 without any stepping of the pair. One word is worked on at a
// time; the next is taken once the previous result sits in the output
// register, even if the master side has not yet taken it.

module fibonacci_mod_pisano
    import fmp_pkg::*;
#(
    parameter int MOD_WIDTH   = 16,
    parameter int INDEX_WIDTH = 63
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // index_n [INDEX_WIDTH-1:0], modulus [INDEX_WIDTH +: MOD_WIDTH], zero padding
    input  wire logic [((INDEX_WIDTH + MOD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // fib_mod [MOD_WIDTH-1:0], zero padding
    output logic [((MOD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int M_TDATA_W = ((MOD_WIDTH + 7) / 8) * 8;

    ctrl_word_t            ctrl;
    fmp_status_t           status;
    logic [MOD_WIDTH-1:0]  fib_mod;

    // Take a word only in the idle step
    assign s_tready = (ctrl.op == OP_LOAD);

    fmp_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .status   (status),
        .ctrl     (ctrl)
    );

    fmp_datapath #(
        .MOD_WIDTH   (MOD_WIDTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .in_valid  (s_tvalid),
        .in_index  (s_tdata[INDEX_WIDTH-1:0]),
        .in_mod    (s_tdata[INDEX_WIDTH +: MOD_WIDTH]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (fib_mod),
        .status    (status)
    );

    // Pad the result to whole bytes
    assign m_tdata = M_TDATA_W'(fib_mod);

endmodule

`default_nettype wire
